FILE: sv/sgm_pkg.sv
// ============================================================================
// sgm_pkg - shared types and constants of the Sobel gradient magnitude block
// Pixel and gradient widths, kernel tables, register indexes and line pair.
// ============================================================================
package sgm_pkg;

   // Pixel and arithmetic widths
   localparam int PIX_W  = 8;
   localparam int GRAD_W = 12;   // signed gradient, |g| <= 1020
   localparam int ABS_W  = 11;   // magnitude of one gradient
   localparam int SQ_W   = 21;   // gx^2 + gy^2 <= 2080800

   typedef logic [PIX_W-1:0] pixel_type;
   typedef logic signed [GRAD_W-1:0] coef_type;

   // Sobel kernels, row major, top row first
   localparam coef_type KERN_X [9] = '{-12'sd1, 12'sd0, 12'sd1,
                                       -12'sd2, 12'sd0, 12'sd2,
                                       -12'sd1, 12'sd0, 12'sd1};
   localparam coef_type KERN_Y [9] = '{-12'sd1, -12'sd2, -12'sd1,
                                        12'sd0,  12'sd0,  12'sd0,
                                        12'sd1,  12'sd2,  12'sd1};

   localparam pixel_type MAG_MAX = 8'd255;

   // Configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 11;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;
   localparam int DIM_RESET = 1024;

   // One line store entry: row two above and row one above a column
   typedef struct packed {
      pixel_type above2;
      pixel_type above1;
   } line_pair_type;

endpackage

FILE: sv/sgm_line_store.sv
// ============================================================================
// sgm_line_store - dual line store in one synchronous memory
// One entry per column holds the two previous rows; read data registered.
// ============================================================================
module sgm_line_store #(
   parameter int DEPTH = 1024
) (
   input  logic                                  clock,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output sgm_pkg::line_pair_type                rd_data,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  sgm_pkg::line_pair_type                wr_data
);
   import sgm_pkg::*;

   line_pair_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: sv/sgm_sqrt.sv
// ============================================================================
// sgm_sqrt - iterative integer square root, saturated to 255
// Settles one result bit per cycle, most significant first.
// ============================================================================
module sgm_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [sgm_pkg::SQ_W-1:0]    operand,
   output logic                        busy,
   output logic                        done,
   output sgm_pkg::pixel_type          root
);
   import sgm_pkg::*;

   localparam int HALF_W = 2 * PIX_W;

   logic [HALF_W-1:0] operand_ff;
   pixel_type         root_ff;
   pixel_type         bit_ff;
   logic              done_ff;
   pixel_type         trial;
   logic [HALF_W-1:0] trial_sq;

   assign trial    = root_ff | bit_ff;
   assign trial_sq = HALF_W'(trial) * HALF_W'(trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff  <= '0;
         done_ff <= 1'b0;
      end else if (start) begin
         if (operand[SQ_W-1:HALF_W] != '0) begin
            // at or above 65536: saturate right away
            root_ff <= MAG_MAX;
            bit_ff  <= '0;
            done_ff <= 1'b1;
         end else begin
            operand_ff <= operand[HALF_W-1:0];
            root_ff    <= '0;
            bit_ff     <= {1'b1, {(PIX_W-1){1'b0}}};
            done_ff    <= 1'b0;
         end
      end else if (bit_ff != '0) begin
         if (trial_sq <= operand_ff) begin
            root_ff <= trial;
         end
         bit_ff  <= bit_ff >> 1;
         done_ff <= (bit_ff == pixel_type'(1));
      end else begin
         done_ff <= 1'b0;
      end
   end

   assign busy = (bit_ff != '0);
   assign done = done_ff;
   assign root = root_ff;

endmodule

FILE: sv/sobel_gradient_magnitude.sv
// ============================================================================
// sobel_gradient_magnitude - streaming 3x3 Sobel gradient magnitude
// Raster pixels in, floor(sqrt(gx^2+gy^2)) saturated to 255 out, borders
// replicated; output k leaves on input transfer k+width+1.
// ============================================================================
// Sequence: one item at a time, as req_tready is high only in S_IDLE; an item that
//   yields a result passes S_READ, S_GRAD, S_SQUARE, S_SQRT (the 8-step square root
//   unit) and S_OUT, which waits for the output register to free up before rsp_tvalid;
//   an item with no result passes S_READ only; a flush dropped in the pixel phase stays idle.
// Reset: synchronous, active high; width and height return to 1024 (clipped to
//   MAX_WIDTH/MAX_HEIGHT), positions and window clear, line store unwritten.
module sobel_gradient_magnitude #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   // input stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // [7:0] pixel
   input  logic                                req_tuser,   // [0] flush
   // result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [7:0]                          rsp_tdata,   // [7:0] magnitude
   output logic                                rsp_tlast,   // line_end
   output logic                                rsp_tuser,   // [0] frame_end
   // configuration writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sgm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sgm_pkg::CSR_DATA_W-1:0]      csr_data
);
   import sgm_pkg::*;

   // Counter widths
   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WID_W = $clog2(MAX_WIDTH + 1);
   localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
   localparam int ROW_W = $clog2(MAX_HEIGHT + 2);
   localparam int RESET_WIDTH  = (DIM_RESET > MAX_WIDTH)  ? MAX_WIDTH  : DIM_RESET;
   localparam int RESET_HEIGHT = (DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT : DIM_RESET;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_READ   = 6'b000010,
      S_GRAD   = 6'b000100,
      S_SQUARE = 6'b001000,
      S_SQRT   = 6'b010000,
      S_OUT    = 6'b100000
   } state_type;

   // Per-item control carried from the line store stage to the output
   typedef struct packed {
      logic left_rep;    // left neighbor replicates the center column
      logic right_rep;   // right neighbor replicates the center column
      logic line_end;
      logic frame_end;
   } item_ctl_type;

   state_type      state_ff, state_in;
   logic [WID_W-1:0] width_ff;
   logic [HGT_W-1:0] height_ff;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   pixel_type      pix_ff;
   pixel_type      win_ff [3][3];   // [column old..new][row top..bottom]
   item_ctl_type   ctl_ff, ctl_in;
   logic [ABS_W-1:0] gx_abs_ff, gy_abs_ff;

   logic           rsp_valid_ff;
   pixel_type      rsp_mag_ff;
   logic           rsp_last_ff;
   logic           rsp_frame_ff;

   // ------------------------------------------------------------------
   // Handshakes
   // ------------------------------------------------------------------
   logic req_xfer, csr_xfer, in_frame, drop_flush, out_load;

   assign csr_ready  = 1'b1;
   assign csr_xfer   = csr_valid & csr_ready;
   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid & req_tready;
   // pixel phase while the row counter is inside the frame
   assign in_frame   = (ROW_W'(height_ff) > row_ff);
   // a flush during the pixel phase changes nothing
   assign drop_flush = req_tuser & in_frame;

   // ------------------------------------------------------------------
   // Line store: read at the current column on transfer, write back next
   // ------------------------------------------------------------------
   line_pair_type rd_pair, wr_pair;
   logic          ls_we;
   pixel_type     mid_px, top_px, bot_px;

   assign mid_px  = rd_pair.above1;
   assign top_px  = (row_ff == ROW_W'(1)) ? mid_px : rd_pair.above2;   // top edge
   assign bot_px  = in_frame ? pix_ff : mid_px;                        // bottom edge
   assign ls_we   = (state_ff == S_READ) && in_frame;
   assign wr_pair = '{above2: mid_px, above1: pix_ff};

   sgm_line_store #(
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (req_xfer & ~drop_flush),
      .rd_addr (col_ff),
      .rd_data (rd_pair),
      .wr_en   (ls_we),
      .wr_addr (col_ff),
      .wr_data (wr_pair)
   );

   // ------------------------------------------------------------------
   // Position bookkeeping for the item in the read stage
   // ------------------------------------------------------------------
   logic emit, last_col, frame_end;

   // results start once width+1 items are in
   assign emit      = (row_ff >= ROW_W'(2)) ||
                      ((row_ff == ROW_W'(1)) && (col_ff != '0));
   assign last_col  = (WID_W'(col_ff) == width_ff - 1'b1);
   assign frame_end = (row_ff == ROW_W'(height_ff) + 1'b1);

   always_comb begin
      ctl_in.left_rep  = ((col_ff == '0) && (width_ff == WID_W'(1))) ||
                         (col_ff == COL_W'(1));
      ctl_in.right_rep = (col_ff == '0);
      ctl_in.line_end  = (col_ff == '0);
      ctl_in.frame_end = frame_end;
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (state_ff == S_READ) begin
         if (emit && frame_end) begin
            // frame done: restart both positions
            col_in = '0;
            row_in = '0;
         end else if (last_col) begin
            col_in = '0;
            row_in = row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Gradients over the shifted window
   // ------------------------------------------------------------------
   logic [1:0]             col_sel [3];
   logic signed [GRAD_W-1:0] gx_sum, gy_sum, pix_ext;

   always_comb begin
      col_sel[0] = ctl_ff.left_rep  ? 2'd1 : 2'd0;
      col_sel[1] = 2'd1;
      col_sel[2] = ctl_ff.right_rep ? 2'd1 : 2'd2;
      gx_sum  = '0;
      gy_sum  = '0;
      pix_ext = '0;
      for (int ky = 0; ky < 3; ky++) begin
         for (int kx = 0; kx < 3; kx++) begin
            pix_ext = $signed({{(GRAD_W-PIX_W){1'b0}}, win_ff[col_sel[kx]][ky]});
            gx_sum  = GRAD_W'(gx_sum + pix_ext * KERN_X[ky*3 + kx]);
            gy_sum  = GRAD_W'(gy_sum + pix_ext * KERN_Y[ky*3 + kx]);
         end
      end
   end

   // ------------------------------------------------------------------
   // Squares and square root
   // ------------------------------------------------------------------
   logic [SQ_W-1:0] sq_sum;
   logic            sq_start, sq_busy, sq_done;
   pixel_type       sq_root;

   assign sq_sum   = SQ_W'(2*ABS_W'(0) + (2*ABS_W)'(gx_abs_ff) * (2*ABS_W)'(gx_abs_ff)
                                       + (2*ABS_W)'(gy_abs_ff) * (2*ABS_W)'(gy_abs_ff));
   assign sq_start = (state_ff == S_SQUARE);

   sgm_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sq_start),
      .operand (sq_sum),
      .busy    (sq_busy),
      .done    (sq_done),
      .root    (sq_root)
   );

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   assign out_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer && !drop_flush) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = emit ? S_GRAD : S_IDLE;
         end
         S_GRAD: begin
            state_in = S_SQUARE;
         end
         S_SQUARE: begin
            state_in = S_SQRT;
         end
         S_SQRT: begin
            if (sq_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // hold until the output register frees up
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Effective dimensions, clipped to 1..MAX
   logic [WID_W-1:0] width_wr;
   logic [HGT_W-1:0] height_wr;

   always_comb begin
      if (csr_data == '0) begin
         width_wr  = WID_W'(1);
         height_wr = HGT_W'(1);
      end else begin
         width_wr  = (32'(csr_data) > 32'(MAX_WIDTH))  ? WID_W'(MAX_WIDTH)  : WID_W'(csr_data);
         height_wr = (32'(csr_data) > 32'(MAX_HEIGHT)) ? HGT_W'(MAX_HEIGHT) : HGT_W'(csr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         width_ff  <= WID_W'(RESET_WIDTH);
         height_ff <= HGT_W'(RESET_HEIGHT);
         col_ff    <= '0;
         row_ff    <= '0;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else if (csr_xfer) begin
         // a register write restarts the frame; line store keeps its data
         if (csr_index == REG_IMAGE_WIDTH) begin
            width_ff <= width_wr;
         end
         if (csr_index == REG_IMAGE_HEIGHT) begin
            height_ff <= height_wr;
         end
         col_ff <= '0;
         row_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         if (state_ff == S_READ) begin
            // advance the window by one column
            for (int j = 0; j < 3; j++) begin
               win_ff[0][j] <= win_ff[1][j];
               win_ff[1][j] <= win_ff[2][j];
            end
            win_ff[2][0] <= top_px;
            win_ff[2][1] <= mid_px;
            win_ff[2][2] <= bot_px;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         pix_ff <= req_tdata;
      end
      if (state_ff == S_READ) begin
         ctl_ff <= ctl_in;
      end
      if (state_ff == S_GRAD) begin
         gx_abs_ff <= ABS_W'(gx_sum[GRAD_W-1] ? -gx_sum : gx_sum);
         gy_abs_ff <= ABS_W'(gy_sum[GRAD_W-1] ? -gy_sum : gy_sum);
      end
      if (out_load) begin
         rsp_mag_ff   <= sq_root;
         rsp_last_ff  <= ctl_ff.line_end;
         rsp_frame_ff <= ctl_ff.frame_end;
      end
   end

   // Output register: load on a free slot, drop after the transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_mag_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_frame_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // the end of a frame is always the end of a line
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("frame_end without line_end");

   // the column counter stays inside the configured width
   assert property (@(posedge clock) disable iff (reset)
      WID_W'(col_ff) < width_ff)
      else $error("column position beyond image width");

   // the square root unit is never restarted mid-run
   assert property (@(posedge clock) disable iff (reset)
      sq_start |-> !sq_busy)
      else $error("square root started while busy");

   // a line store write follows a read issued in the cycle before
   assert property (@(posedge clock) disable iff (reset)
      ls_we |-> $past(req_xfer))
      else $error("line store write without a preceding read");

endmodule

FILE: sim/sobel_gradient_magnitude_test.sv
`timescale 1ns / 1ps
// ============================================================================
// sobel_gradient_magnitude_test - self-checking bench for the Sobel block
// Streams raster frames of random size and content through the block, sets
// image size between frames, and checks every output pixel against a local
// line-store and window model of the 3x3 gradient magnitude.
// ============================================================================
module sobel_gradient_magnitude_test;
   import sgm_pkg::*;

   localparam int MAX_DIM         = 1024;
   localparam int LATENCY         = 13;     // input transfer to rsp_tvalid
   localparam int SETTLE_CYCLES   = LATENCY + 8;
   localparam int RSP_HOLD_CYCLES = 400;    // long receiver stall, fills the block
   // Longest quiet stretch of a correct run is the receiver hold plus one gap
   // and one result time; take it several times over.
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int RANDOM_ITEMS    = 1750;

   // One output pixel as it leaves the block
   typedef struct packed {
      pixel_type magnitude;
      logic      line_end;
      logic      frame_end;
   } grad_result_type;

   typedef enum logic [1:0] {STEP_REG, STEP_PIXEL, STEP_FLUSH} step_kind_type;

   // One row of the directed table; result is used only when fixed is set
   typedef struct packed {
      step_kind_type              kind;
      logic [CSR_IDX_W-1:0]       reg_index;
      logic [CSR_DATA_W-1:0]      reg_value;
      pixel_type                  pixel;
      logic                       fixed;
      logic                       yields;
      grad_result_type            result;
   } script_step_type;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata  = '0;   // [7:0] pixel
   logic                   req_tuser  = 1'b0; // [0] flush
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [7:0]             rsp_tdata;         // [7:0] magnitude
   logic                   rsp_tlast;         // line_end
   logic                   rsp_tuser;         // [0] frame_end
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   // Shadow of the block: registers, two line stores, 3x3 window, positions
   logic [CSR_DATA_W-1:0]  width_reg  = CSR_DATA_W'(DIM_RESET);
   logic [CSR_DATA_W-1:0]  height_reg = CSR_DATA_W'(DIM_RESET);
   pixel_type              line_above1 [MAX_DIM];
   pixel_type              line_above2 [MAX_DIM];
   logic [2:0][7:0]        cols [3];          // [column old..new][row top..bottom]
   int unsigned            in_count   = 0;
   int unsigned            out_count  = 0;

   grad_result_type        grad_due [$];      // output pixels still to come
   script_step_type        script [$];
   int unsigned            fail_count   = 0;
   int unsigned            report_count = 0;
   int unsigned            items_played = 0;
   int unsigned            req_gap_max  = 14;
   int unsigned            rsp_gap_max  = 14;
   bit                     rsp_hold_req = 1'b0;

   sobel_gradient_magnitude u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      foreach (line_above1[i]) begin
         line_above1[i] = '0;
         line_above2[i] = '0;
      end
      foreach (cols[i]) cols[i] = '0;
   end

   // Clip a size register into 1..MAX_DIM
   function automatic int unsigned clamp_dim(input int unsigned v);
      if (v < 1) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
   endfunction

   // Weighted column sum (1,2,1 down the rows) for the horizontal kernel
   function automatic int col_weight(input int c);
      return int'(cols[c][0]) + 2 * int'(cols[c][1]) + int'(cols[c][2]);
   endfunction

   // Gradient magnitude over the window, with left/center/right column picks
   // that express border replication
   function automatic pixel_type kernel_mag(input int lc, input int cc, input int rc);
      int gx;
      int gy;
      int sq;
      int r;
      gx = col_weight(rc) - col_weight(lc);
      gy = (int'(cols[lc][2]) + 2 * int'(cols[cc][2]) + int'(cols[rc][2]))
         - (int'(cols[lc][0]) + 2 * int'(cols[cc][0]) + int'(cols[rc][0]));
      sq = gx * gx + gy * gy;
      r = 0;
      // integer square root, saturated at the top of the pixel range
      while (r < 255 && (r + 1) * (r + 1) <= sq) r++;
      return pixel_type'(r);
   endfunction

   // Advance the shadow by one accepted item; return 1 when it yields a pixel
   function automatic logic predict_gradient(input pixel_type pixel, input logic flush,
                                             output grad_result_type res);
      int unsigned w;
      int unsigned h;
      int unsigned total;
      int unsigned line_idx;
      int unsigned col;
      int unsigned k;
      pixel_type   top;
      pixel_type   mid;
      pixel_type   bot;
      pixel_type   mag;
      logic        emit;
      w     = clamp_dim(width_reg);
      h     = clamp_dim(height_reg);
      total = w * h;
      res   = '0;
      mag   = '0;
      // a flush while pixels are still due is dropped without a trace
      if (in_count < total && flush) return 1'b0;
      line_idx = in_count / w;
      col      = in_count % w;
      mid      = line_above1[col];
      top      = line_above2[col];
      if (line_idx < h) begin
         bot = pixel;
         line_above2[col] = mid;
         line_above1[col] = bot;
      end else begin
         bot = mid;   // drain: replicate the bottom line
      end
      if (line_idx == 1) top = mid;   // replicate the top line
      emit = (in_count >= w + 1) && (out_count < total);
      k    = out_count;
      // at a line start the last column of the previous line is the right edge
      if (emit && col == 0) mag = kernel_mag(w == 1 ? 2 : 1, 2, 2);
      cols[0] = cols[1];
      cols[1] = cols[2];
      cols[2] = {bot, mid, top};
      if (emit && col != 0) mag = kernel_mag((k % w) == 0 ? 1 : 0, 1, 2);
      in_count++;
      if (!emit) return 1'b0;
      res.magnitude = mag;
      res.line_end  = (k % w) == w - 1;
      res.frame_end = k == total - 1;
      out_count = k + 1;
      if (out_count >= total) begin
         in_count  = 0;
         out_count = 0;
      end
      return 1'b1;
   endfunction

   function automatic script_step_type stim_row(
         input step_kind_type kind, input logic [CSR_IDX_W-1:0] index,
         input logic [CSR_DATA_W-1:0] value, input pixel_type pixel, input logic fixed,
         input logic yields, input pixel_type mag, input logic le, input logic fe);
      script_step_type s;
      s.kind      = kind;
      s.reg_index = index;
      s.reg_value = value;
      s.pixel     = pixel;
      s.fixed     = fixed;
      s.yields    = yields;
      s.result    = {mag, le, fe};
      return s;
   endfunction

   // Mostly random gray, sometimes black or white to hit saturation
   function automatic pixel_type draw_pixel();
      if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      return pixel_type'($urandom_range(0, 255));
   endfunction

   // Size register value: mostly small, a few wider, now and then zero
   function automatic logic [CSR_DATA_W-1:0] draw_dim(input int unsigned typical,
                                                      input int unsigned wide);
      case ($urandom_range(0, 15))
         0: return '0;
         1, 2: return $urandom_range(typical + 1, wide);
         default: return $urandom_range(1, typical);
      endcase
   endfunction

   // Offer one item after a random gap, hold it until the transfer, then
   // queue what it yields (the table value where one is fixed)
   task automatic push_item(input pixel_type pixel, input logic flush, input logic fixed,
                            input logic yields, input grad_result_type known);
      int unsigned     gap;
      grad_result_type res;
      logic            emitted;
      gap = $urandom_range(0, req_gap_max);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pixel;
      req_tuser  <= flush;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      emitted = predict_gradient(pixel, flush, res);
      if (fixed) begin
         emitted = yields;
         res     = known;
      end
      if (emitted) grad_due.push_back(res);
      @(negedge clock);
   endtask

   // Drop valid, wait for every due pixel, then let the block finish any
   // item that yields nothing
   task automatic rest_until_idle();
      req_tvalid <= 1'b0;
      while (grad_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // One register write; a write restarts the frame but keeps the line stores
   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (index == REG_IMAGE_WIDTH) begin
         width_reg = value;
      end else begin
         height_reg = value;
      end
      foreach (cols[i]) cols[i] = '0;
      in_count  = 0;
      out_count = 0;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Set the size, then stream whole frames (pixels plus drain), or cut the
   // first one short so that the next write lands in mid-frame
   task automatic play_frames(input logic [CSR_DATA_W-1:0] w_raw,
                              input logic [CSR_DATA_W-1:0] h_raw,
                              input int unsigned frames, input logic cut_short,
                              input logic pause_mid);
      int unsigned w;
      int unsigned total;
      int unsigned span;
      int unsigned stop_at;
      int unsigned n;
      int unsigned pos;
      rest_until_idle();
      write_reg(REG_IMAGE_WIDTH, w_raw);
      write_reg(REG_IMAGE_HEIGHT, h_raw);
      w       = clamp_dim(w_raw);
      total   = w * clamp_dim(h_raw);
      span    = total + w + 1;
      stop_at = cut_short ? $urandom_range(1, span - 1) : frames * span;
      for (n = 0; n < stop_at; n++) begin
         pos = n % span;
         // stray flush among the pixels: the block drops it
         if (pos < total && $urandom_range(0, 15) == 0)
            push_item(draw_pixel(), 1'b1, 1'b0, 1'b0, '0);
         // in the drain any item acts as a flush, so mix in plain pixels
         push_item(draw_pixel(), pos >= total && $urandom_range(0, 3) != 0,
                   1'b0, 1'b0, '0);
         if (pause_mid && n == stop_at / 2) begin
            // hold the sender until the block has handed over everything
            req_tvalid <= 1'b0;
            do @(negedge clock); while (grad_due.size() != 0);
         end
      end
      items_played += stop_at;
   endtask

   // Result side: random stalls, one long hold on request, in-order compare
   initial begin : result_sink
      int unsigned     gap;
      grad_result_type got;
      grad_result_type want;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = rsp_hold_req ? RSP_HOLD_CYCLES : $urandom_range(0, rsp_gap_max);
         rsp_hold_req = 1'b0;
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         got = {rsp_tdata, rsp_tlast, rsp_tuser};
         if (grad_due.size() == 0) begin
            fail_count++;
            if (report_count < 10) begin
               report_count++;
               $display("unexpected output pixel: magnitude %0d line_end %0d frame_end %0d",
                        got.magnitude, got.line_end, got.frame_end);
            end
         end else begin
            want = grad_due.pop_front();
            if (got.magnitude !== want.magnitude || got.line_end !== want.line_end ||
                got.frame_end !== want.frame_end) begin
               fail_count++;
               if (report_count < 10) begin
                  report_count++;
                  $display("pixel mismatch: expected mag %0d le %0d fe %0d, got mag %0d le %0d fe %0d",
                           want.magnitude, want.line_end, want.frame_end,
                           got.magnitude, got.line_end, got.frame_end);
               end
            end
         end
         @(negedge clock);
      end
   end

   // End the run when no channel has moved a transfer for too long
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      int unsigned phase;
      logic [CSR_DATA_W-1:0] w_raw;
      logic [CSR_DATA_W-1:0] h_raw;

      // Directed rows. After reset the frame is 1024x1024, so nothing comes
      // out; a flush among pixels is dropped.
      script.push_back(stim_row(STEP_PIXEL, '0, '0, 8'h00, 1, 0, 0, 0, 0));
      script.push_back(stim_row(STEP_PIXEL, '0, '0, 8'hFF, 1, 0, 0, 0, 0));
      script.push_back(stim_row(STEP_FLUSH, '0, '0, 8'h3C, 1, 0, 0, 0, 0));
      // Zero sizes clip to a 1x1 frame: one pixel, two drain items; the second
      // drain item carries a pixel and still acts as a flush. Flat window.
      script.push_back(stim_row(STEP_REG, REG_IMAGE_WIDTH, 11'd0, '0, 0, 0, 0, 0, 0));
      script.push_back(stim_row(STEP_REG, REG_IMAGE_HEIGHT, 11'd0, '0, 0, 0, 0, 0, 0));
      script.push_back(stim_row(STEP_PIXEL, '0, '0, 8'hA5, 1, 0, 0, 0, 0));
      script.push_back(stim_row(STEP_FLUSH, '0, '0, 8'h00, 1, 0, 0, 0, 0));
      script.push_back(stim_row(STEP_PIXEL, '0, '0, 8'h5A, 1, 1, 0, 1, 1));
      // 2x1 black-to-white step: both pixels saturate
      script.push_back(stim_row(STEP_REG, REG_IMAGE_WIDTH, 11'd2, '0, 0, 0, 0, 0, 0));
      script.push_back(stim_row(STEP_PIXEL, '0, '0, 8'h00, 1, 0, 0, 0, 0));
      script.push_back(stim_row(STEP_PIXEL, '0, '0, 8'hFF, 1, 0, 0, 0, 0));
      script.push_back(stim_row(STEP_FLUSH, '0, '0, 8'h00, 1, 0, 0, 0, 0));
      script.push_back(stim_row(STEP_FLUSH, '0, '0, 8'h00, 1, 1, MAG_MAX, 0, 0));
      script.push_back(stim_row(STEP_FLUSH, '0, '0, 8'h00, 1, 1, MAG_MAX, 1, 1));
      // 2x2 with a stray flush among pixels; checked by the model
      script.push_back(stim_row(STEP_REG, REG_IMAGE_HEIGHT, 11'd2, '0, 0, 0, 0, 0, 0));
      script.push_back(stim_row(STEP_PIXEL, '0, '0, 8'h12, 0, 0, 0, 0, 0));
      script.push_back(stim_row(STEP_FLUSH, '0, '0, 8'hFF, 0, 0, 0, 0, 0));
      script.push_back(stim_row(STEP_PIXEL, '0, '0, 8'hC3, 0, 0, 0, 0, 0));
      script.push_back(stim_row(STEP_PIXEL, '0, '0, 8'h7E, 0, 0, 0, 0, 0));
      script.push_back(stim_row(STEP_PIXEL, '0, '0, 8'h01, 0, 0, 0, 0, 0));
      script.push_back(stim_row(STEP_FLUSH, '0, '0, 8'h00, 0, 0, 0, 0, 0));
      script.push_back(stim_row(STEP_PIXEL, '0, '0, 8'h80, 0, 0, 0, 0, 0));
      script.push_back(stim_row(STEP_FLUSH, '0, '0, 8'h00, 0, 0, 0, 0, 0));

      // Hold reset, then release it on a falling edge
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         if (script[i].kind == STEP_REG) begin
            rest_until_idle();
            write_reg(script[i].reg_index, script[i].reg_value);
         end else begin
            push_item(script[i].pixel, script[i].kind == STEP_FLUSH, script[i].fixed,
                      script[i].yields, script[i].result);
         end
      end

      // Random frames, small sizes; each phase picks its own idling mix
      phase = 0;
      while (items_played < RANDOM_ITEMS) begin
         req_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 14;
         rsp_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 14;
         w_raw = draw_dim(8, 40);
         h_raw = draw_dim(6, 12);
         if (phase == 2) begin
            // receiver holds off while the sender keeps offering at full rate
            req_gap_max  = 0;
            rsp_hold_req = 1'b1;
            play_frames(11'd8, 11'd6, 1, 1'b0, 1'b0);
         end else begin
            play_frames(w_raw, h_raw, $urandom_range(1, 2), $urandom_range(0, 7) == 0,
                        phase == 4);
         end
         phase++;
      end

      // Widest line, then tallest frame (register values at or past the top clip)
      play_frames(11'd2047, $urandom_range(0, 1), 1, 1'b0, 1'b0);
      play_frames($urandom_range(0, 1), $urandom_range(1024, 2047), 1, 1'b0, 1'b0);

      rest_until_idle();
      if (fail_count == 0 && grad_due.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
